FILE: hw/rtl/cdof_pkg.sv
package cdof_pkg;

    localparam int unsigned OpWidth = 11;
    localparam logic [OpWidth-1:0] WantedReset = 11'd17;
    localparam logic [OpWidth-1:0] EscBase = 11'd1200;

    localparam logic [1:0] ST_FOUND_OPERAND = 2'd0;
    localparam logic [1:0] ST_FOUND_EMPTY   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND     = 2'd2;
    localparam logic [1:0] ST_RESERVED      = 2'd3;

    localparam logic [7:0] BYTE_ESC      = 8'd12;
    localparam logic [7:0] BYTE_OP_MAX   = 8'd21;
    localparam logic [7:0] BYTE_INT16    = 8'd28;
    localparam logic [7:0] BYTE_INT32    = 8'd29;
    localparam logic [7:0] BYTE_REAL     = 8'd30;
    localparam logic [7:0] BYTE_SMALL_LO = 8'd32;
    localparam logic [7:0] BYTE_SMALL_HI = 8'd246;
    localparam logic [7:0] BYTE_POS_LO   = 8'd247;
    localparam logic [7:0] BYTE_POS_HI   = 8'd250;
    localparam logic [7:0] BYTE_NEG_LO   = 8'd251;
    localparam logic [7:0] BYTE_NEG_HI   = 8'd254;
    localparam logic [8:0] SmallBias     = 9'd139;
    localparam logic [10:0] WordBias     = 11'd108;

    typedef struct packed {
        logic [7:0] dict_byte;
        logic       end_of_dict;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] operand_value;
    } t_out_word;

endpackage

FILE: hw/rtl/cff_dict_operand_finder.sv
// CFF DICT operand finder.
// The input channel takes one DICT byte per word, with end_of_dict set on the
// final byte. The output channel gives at most one word per DICT: the status
// and, when the wanted operator was found after an operand, that operand.
// The wanted operator is set through the configuration write port; the user
// must write it only while the block is idle (the block does not enforce it).
// Escaped operators are written as 1200 plus the second byte. One byte is
// accepted in every cycle while the input stall is low. The decode state is
// updated from the byte; the result that a byte decides is registered into
// the output register, or into the one-word skid register behind it while the
// output is held, so a byte is still accepted while a finished result waits.
// The block raises its input stall only while the skid register is full,
// which takes two results held back by the receiver. Results are never
// dropped or reordered. Reset clears the decode state and both output valid
// flags, sets the wanted operator to 17. After a decision, bytes are consumed
// without result until the end of the DICT, which returns the decoder to idle.
module cff_dict_operand_finder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [10:0]                i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cdof_pkg::t_in_word         i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output cdof_pkg::t_out_word        o_out_word
);
    import cdof_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ESC  = 3'd1;
    localparam logic [2:0] PH_INT  = 3'd2;
    localparam logic [2:0] PH_REAL = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [OpWidth-1:0] r_wanted;
    logic [2:0]         r_phase, n_phase;
    logic [7:0]         r_lead, n_lead;
    logic [2:0]         r_pending, n_pending;
    logic [31:0]        r_partial, n_partial;
    logic [31:0]        r_last, n_last;
    logic               r_present, n_present;

    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;
    logic               r_skid_valid, n_skid_valid;
    t_out_word          r_skid_word, n_skid_word;

    logic               accept;
    logic               emit;
    t_out_word          res;
    logic [7:0]         b;
    logic [OpWidth-1:0] op_code;
    logic               is_op;
    logic [31:0]        shifted;
    logic [31:0]        int_value;
    logic [10:0]        word_mag;
    logic [8:0]         small_value;
    logic               out_free;

    assign b        = i_in_word.dict_byte;
    assign accept   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign shifted  = {r_partial[23:0], b};
    assign small_value = {1'b0, b} - SmallBias;

    always_comb begin
        if (r_lead <= BYTE_POS_HI) begin
            word_mag = {1'b0, 2'(r_lead - BYTE_POS_LO), b} + WordBias;
        end else begin
            word_mag = {1'b0, 2'(r_lead - BYTE_NEG_LO), b} + WordBias;
        end
        if (r_lead == BYTE_INT16) begin
            int_value = {{16{shifted[15]}}, shifted[15:0]};
        end else if (r_lead == BYTE_INT32) begin
            int_value = shifted;
        end else if (r_lead <= BYTE_POS_HI) begin
            int_value = {21'd0, word_mag};
        end else begin
            int_value = 32'd0 - {21'd0, word_mag};
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_lead    = r_lead;
        n_pending = r_pending;
        n_partial = r_partial;
        n_last    = r_last;
        n_present = r_present;
        emit      = 1'b0;
        res.status        = ST_NOT_FOUND;
        res.operand_value = -32'sd1;
        is_op     = 1'b0;
        op_code   = {3'd0, b};

        case (r_phase)
            PH_IDLE: begin
                if (b == BYTE_ESC) begin
                    n_phase = PH_ESC;
                end else if (b <= BYTE_OP_MAX) begin
                    is_op = 1'b1;
                end else if (b == BYTE_INT16 || b == BYTE_INT32) begin
                    n_lead    = b;
                    n_pending = (b == BYTE_INT16) ? 3'd2 : 3'd4;
                    n_partial = 32'd0;
                    n_phase   = PH_INT;
                end else if (b == BYTE_REAL) begin
                    n_phase = PH_REAL;
                end else if (b >= BYTE_SMALL_LO && b <= BYTE_SMALL_HI) begin
                    n_last    = {{23{small_value[8]}}, small_value};
                    n_present = 1'b1;
                end else if (b >= BYTE_POS_LO && b <= BYTE_NEG_HI) begin
                    n_lead    = b;
                    n_pending = 3'd1;
                    n_partial = 32'd0;
                    n_phase   = PH_INT;
                end else begin
                    emit       = 1'b1;
                    res.status = ST_RESERVED;
                    n_phase    = PH_DONE;
                end
            end
            PH_ESC: begin
                is_op   = 1'b1;
                op_code = EscBase + {3'd0, b};
            end
            PH_INT: begin
                n_partial = shifted;
                n_pending = r_pending - 3'd1;
                if (r_pending == 3'd1) begin
                    n_last    = int_value;
                    n_present = 1'b1;
                    n_phase   = PH_IDLE;
                end
            end
            PH_REAL: begin
                if (b[3:0] == 4'hF || b[7:4] == 4'hF) begin
                    n_last    = 32'd0;
                    n_present = 1'b1;
                    n_phase   = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (is_op) begin
            if (op_code == r_wanted) begin
                emit    = 1'b1;
                n_phase = PH_DONE;
                if (r_present) begin
                    res.status        = ST_FOUND_OPERAND;
                    res.operand_value = r_last;
                end else begin
                    res.status = ST_FOUND_EMPTY;
                end
            end else begin
                n_present = 1'b0;
                n_last    = 32'd0;
                n_phase   = PH_IDLE;
            end
        end

        if (i_in_word.end_of_dict) begin
            if (!emit && r_phase != PH_DONE) begin
                emit       = 1'b1;
                res.status = ST_NOT_FOUND;
            end
            n_phase   = PH_IDLE;
            n_lead    = 8'd0;
            n_pending = 3'd0;
            n_partial = 32'd0;
            n_last    = 32'd0;
            n_present = 1'b0;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_skid_valid = r_skid_valid;
        n_skid_word  = r_skid_word;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_word   = r_skid_word;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = accept && emit;
                n_out_word  = res;
            end
        end else if (accept && emit) begin
            n_skid_valid = 1'b1;
            n_skid_word  = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted     <= WantedReset;
            r_phase      <= PH_IDLE;
            r_lead       <= 8'd0;
            r_pending    <= 3'd0;
            r_partial    <= 32'd0;
            r_last       <= 32'd0;
            r_present    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wanted <= i_cfg_wr_data;
            end
            if (accept) begin
                r_phase   <= n_phase;
                r_lead    <= n_lead;
                r_pending <= n_pending;
                r_partial <= n_partial;
                r_last    <= n_last;
                r_present <= n_present;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: hw/rtl/cdof_checker.sv
module cdof_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cdof_pkg::t_out_word o_out_word
);
    import cdof_pkg::*;

    // A result held by the receiver stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // After reset no word is pending on either side.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall set after reset");

    // Only a found operand carries a value other than minus one.
    a_value_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_FOUND_OPERAND
        |-> o_out_word.operand_value == -32'sd1)
        else $error("operand value without a found operand");

    // The input is held back only while a result waits on the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty output");

    // The input stall is raised only by a result held back by the receiver.
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall raised without a held result");

endmodule

bind cff_dict_operand_finder cdof_checker u_cdof_checker (.*);

FILE: verif/testbench.sv
module testbench;

    import cdof_pkg::*;

    typedef logic [7:0] byte_list_t[$];

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_ESC,
        SCAN_INT,
        SCAN_REAL,
        SCAN_DONE
    } scan_phase_e;

    typedef enum int {
        RECV_STEADY,
        RECV_NORMAL,
        RECV_HEAVY
    } recv_mode_e;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int BYTES_PER_SETTING = 200;
    localparam logic [3:0] NIBBLE_END = 4'hF;
    localparam logic [7:0] RESERVED_TOP = 8'd255;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [10:0] cfg_wr_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_word   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_word  out_word;

    // Predicted decoder state.
    logic [10:0] wanted_op = WantedReset;
    scan_phase_e scan_phase = SCAN_IDLE;
    logic [7:0]  lead = '0;
    int unsigned pending = 0;
    logic [31:0] partial = '0;
    logic [31:0] top_operand = '0;
    logic        has_operand = 1'b0;

    t_out_word  expected_finds[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         bytes_sent = 0;
    bit         sender_steady = 1'b0;
    recv_mode_e recv_mode = RECV_NORMAL;
    int         stall_left = 0;
    int         stall_roll;

    cff_dict_operand_finder dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_word    (in_word),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_word   (out_word)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("Run did not finish within %0d cycles.", CYCLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void clear_scan();
        scan_phase = SCAN_IDLE;
        lead = '0;
        pending = 0;
        partial = '0;
        top_operand = '0;
        has_operand = 1'b0;
    endfunction

    function automatic void push_find(logic [1:0] status, logic [31:0] value);
        t_out_word res;
        res.status = status;
        res.operand_value = value;
        expected_finds.insert(expected_finds.size(), res);
    endfunction

    function automatic logic match_operator(int code);
        if (code == int'(wanted_op)) begin
            if (has_operand) begin
                push_find(ST_FOUND_OPERAND, top_operand);
            end else begin
                push_find(ST_FOUND_EMPTY, '1);
            end
            scan_phase = SCAN_DONE;
            return 1'b1;
        end
        has_operand = 1'b0;
        top_operand = '0;
        scan_phase = SCAN_IDLE;
        return 1'b0;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        logic decided;
        logic was_done;
        decided = 1'b0;
        was_done = (scan_phase == SCAN_DONE);
        case (scan_phase)
            SCAN_IDLE: begin
                if (b == BYTE_ESC) begin
                    scan_phase = SCAN_ESC;
                end else if (b <= BYTE_OP_MAX) begin
                    decided = match_operator(int'(b));
                end else if (b == BYTE_INT16 || b == BYTE_INT32) begin
                    lead = b;
                    pending = (b == BYTE_INT16) ? 2 : 4;
                    partial = '0;
                    scan_phase = SCAN_INT;
                end else if (b == BYTE_REAL) begin
                    scan_phase = SCAN_REAL;
                end else if (b >= BYTE_SMALL_LO && b <= BYTE_SMALL_HI) begin
                    top_operand = 32'(int'(b) - int'(SmallBias));
                    has_operand = 1'b1;
                end else if (b >= BYTE_POS_LO && b <= BYTE_NEG_HI) begin
                    lead = b;
                    pending = 1;
                    partial = '0;
                    scan_phase = SCAN_INT;
                end else begin
                    push_find(ST_RESERVED, '1);
                    decided = 1'b1;
                    scan_phase = SCAN_DONE;
                end
            end
            SCAN_ESC: begin
                decided = match_operator(int'(EscBase) + int'(b));
            end
            SCAN_INT: begin
                partial = {partial[23:0], b};
                pending--;
                if (pending == 0) begin
                    if (lead == BYTE_INT16) begin
                        top_operand = {{16{partial[15]}}, partial[15:0]};
                    end else if (lead == BYTE_INT32) begin
                        top_operand = partial;
                    end else if (lead <= BYTE_POS_HI) begin
                        top_operand = 32'((int'(lead) - int'(BYTE_POS_LO)) * 256
                                          + int'(partial[7:0]) + int'(WordBias));
                    end else begin
                        top_operand = 32'(-((int'(lead) - int'(BYTE_NEG_LO)) * 256
                                            + int'(partial[7:0]) + int'(WordBias)));
                    end
                    has_operand = 1'b1;
                    scan_phase = SCAN_IDLE;
                end
            end
            SCAN_REAL: begin
                if (b[3:0] == NIBBLE_END || b[7:4] == NIBBLE_END) begin
                    top_operand = '0;
                    has_operand = 1'b1;
                    scan_phase = SCAN_IDLE;
                end
            end
            default: begin
            end
        endcase
        if (last) begin
            if (!decided && !was_done) begin
                push_find(ST_NOT_FOUND, '1);
            end
            clear_scan();
        end
    endfunction

    // Result checker.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_finds.size() == 0) begin
                $error("Unexpected result word: status %0d operand %0d",
                       out_word.status, out_word.operand_value);
                mismatch_count++;
            end else begin
                if (out_word.status !== expected_finds[0].status) begin
                    $error("status: expected %0d, got %0d",
                           expected_finds[0].status, out_word.status);
                    mismatch_count++;
                end
                if (out_word.operand_value !== expected_finds[0].operand_value) begin
                    $error("operand_value: expected %0d, got %0d",
                           expected_finds[0].operand_value, out_word.operand_value);
                    mismatch_count++;
                end
                void'(expected_finds.pop_front());
            end
        end
    end

    // Receiver stall generator.
    always @(posedge clk) begin
        if (!rst_n || recv_mode == RECV_STEADY) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < ((recv_mode == RECV_HEAVY) ? 20 : 75)) begin
                out_stall <= 1'b0;
            end else begin
                if (recv_mode == RECV_HEAVY || $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(8, 40);
                end else begin
                    stall_left = $urandom_range(0, 2);
                end
                out_stall <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_steady || roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{dict_byte: b, end_of_dict: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_dict(input byte_list_t dict);
        foreach (dict[i]) begin
            send_byte(dict[i], i == dict.size() - 1);
        end
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_finds.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_wanted(input logic [10:0] code);
        settle_block();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= code;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        wanted_op = code;
    endtask

    task automatic add_operand(ref byte_list_t q);
        case ($urandom_range(0, 5))
            1: begin
                q.insert(q.size(), 8'($urandom_range(BYTE_POS_LO, BYTE_NEG_HI)));
                q.insert(q.size(), 8'($urandom));
            end
            2: begin
                q.insert(q.size(), BYTE_INT16);
                repeat (2) q.insert(q.size(), 8'($urandom));
            end
            3: begin
                q.insert(q.size(), BYTE_INT32);
                repeat (4) q.insert(q.size(), 8'($urandom));
            end
            4: begin
                q.insert(q.size(), BYTE_REAL);
                repeat ($urandom_range(0, 3)) begin
                    q.insert(q.size(),
                             {4'($urandom_range(0, 14)), 4'($urandom_range(0, 14))});
                end
                case ($urandom_range(0, 2))
                    0: q.insert(q.size(), {4'($urandom_range(0, 14)), NIBBLE_END});
                    1: q.insert(q.size(), {NIBBLE_END, 4'($urandom_range(0, 14))});
                    default: q.insert(q.size(), {NIBBLE_END, NIBBLE_END});
                endcase
            end
            default: begin
                q.insert(q.size(), 8'($urandom_range(BYTE_SMALL_LO, BYTE_SMALL_HI)));
            end
        endcase
    endtask

    task automatic add_operator(ref byte_list_t q, input bit want_it);
        logic [7:0] b;
        if (want_it && wanted_op >= EscBase) begin
            q.insert(q.size(), BYTE_ESC);
            q.insert(q.size(), 8'(wanted_op - EscBase));
        end else if (want_it && wanted_op <= 11'(BYTE_OP_MAX)
                     && wanted_op != 11'(BYTE_ESC)) begin
            q.insert(q.size(), 8'(wanted_op));
        end else begin
            b = 8'($urandom_range(0, BYTE_OP_MAX));
            q.insert(q.size(), b);
            if (b == BYTE_ESC) begin
                q.insert(q.size(), 8'($urandom));
            end
        end
    endtask

    task automatic send_random_dict();
        byte_list_t dict;
        int roll;
        dict = {};
        repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(0, 3)) add_operand(dict);
            add_operator(dict, $urandom_range(0, 99) < 35);
        end
        case ($urandom_range(0, 9))
            0: begin
                repeat ($urandom_range(1, 6)) dict.insert(dict.size(), 8'($urandom));
            end
            1: begin
                roll = $urandom_range(0, 7);
                dict.insert(dict.size(), (roll < 6) ? 8'(22 + roll)
                                         : ((roll == 6) ? 8'd31 : RESERVED_TOP));
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: begin
                        dict.insert(dict.size(), BYTE_INT16);
                        repeat ($urandom_range(0, 1)) dict.insert(dict.size(), 8'($urandom));
                    end
                    1: begin
                        dict.insert(dict.size(), BYTE_INT32);
                        repeat ($urandom_range(0, 3)) dict.insert(dict.size(), 8'($urandom));
                    end
                    2: dict.insert(dict.size(), 8'($urandom_range(BYTE_POS_LO, BYTE_NEG_HI)));
                    3: begin
                        dict.insert(dict.size(), BYTE_REAL);
                        repeat ($urandom_range(0, 2)) dict.insert(dict.size(), 8'h00);
                    end
                    default: dict.insert(dict.size(), BYTE_ESC);
                endcase
            end
            default: begin
            end
        endcase
        if (dict.size() == 0) begin
            dict.insert(dict.size(), 8'($urandom));
        end
        send_dict(dict);
    endtask

    task automatic test_directed_cases();
        logic [7:0] op17;
        op17 = WantedReset[7:0];
        sender_steady = 1'b1;
        recv_mode = RECV_STEADY;
        send_dict({8'd246, op17, 8'd5});
        send_dict({BYTE_INT16, 8'h80, 8'h00, BYTE_OP_MAX, op17});
        send_dict({BYTE_NEG_HI, 8'hFF, op17});
        send_dict({BYTE_REAL, 8'h1F, op17});
        send_dict({RESERVED_TOP});
        send_dict({BYTE_POS_LO, 8'h00, 8'h00});
        send_dict({BYTE_INT16, 8'h05});
    endtask

    task automatic test_escape_and_extremes();
        set_wanted(11'd1455);
        send_dict({BYTE_ESC, 8'hFF});
        send_dict({8'd246, BYTE_ESC, 8'hFF, 8'd9});
        send_dict({BYTE_ESC});
        set_wanted(11'd0);
        send_dict({BYTE_INT32, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00});
        send_dict({BYTE_REAL, 8'h12, 8'hF0, 8'h00, 8'h00});
    endtask

    task automatic test_output_backpressure();
        set_wanted(WantedReset);
        sender_steady = 1'b1;
        recv_mode = RECV_HEAVY;
        repeat (40) send_byte(8'($urandom), 1'b1);
        settle_block();
    endtask

    task automatic test_random_dicts();
        logic [10:0] settings[$];
        int start;
        settings = {11'd0, 11'd1455, WantedReset, EscBase, 11'(BYTE_OP_MAX),
                    11'($urandom_range(0, BYTE_OP_MAX)),
                    11'($urandom_range(1200, 1455)), 11'($urandom_range(0, 1455))};
        foreach (settings[i]) begin
            set_wanted(settings[i]);
            recv_mode = recv_mode_e'($urandom_range(0, 3) == 0 ? RECV_STEADY :
                                     ($urandom_range(0, 3) == 0 ? RECV_HEAVY : RECV_NORMAL));
            start = bytes_sent;
            while (bytes_sent - start < BYTES_PER_SETTING) begin
                sender_steady = ($urandom_range(0, 3) == 0);
                send_random_dict();
                if ($urandom_range(0, 24) == 0) begin
                    settle_block();
                end
            end
        end
    endtask

    initial begin
        clear_scan();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_escape_and_extremes();
        test_output_backpressure();
        test_random_dicts();
        settle_block();
        repeat (8) @(posedge clk);
        if (expected_finds.size() != 0) begin
            $error("%0d expected results never arrived", expected_finds.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
